// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [2:0] MODE_ENQ  = 3'd0;
  localparam logic [2:0] MODE_DEQ  = 3'd1;
  localparam logic [2:0] MODE_PEEK = 3'd2;
  localparam logic [2:0] MODE_FIND = 3'd3;
  localparam logic [2:0] MODE_READ = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // index register operations
  localparam logic [2:0] IDX_HOLD = 3'd0;
  localparam logic [2:0] IDX_CNT  = 3'd1;
  localparam logic [2:0] IDX_ZERO = 3'd2;
  localparam logic [2:0] IDX_ONE  = 3'd3;
  localparam logic [2:0] IDX_POS  = 3'd4;
  localparam logic [2:0] IDX_INC  = 3'd5;
  localparam logic [2:0] IDX_DEC  = 3'd6;

  // memory address sources
  localparam logic [1:0] ADDR_IDX  = 2'd0;
  localparam logic [1:0] ADDR_IDXM = 2'd1;
  localparam logic [1:0] ADDR_ZERO = 2'd2;
  localparam logic [1:0] ADDR_POS  = 2'd3;

  // count operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // staged result entry sources
  localparam logic [1:0] ENT_NONE  = 2'd0;
  localparam logic [1:0] ENT_REQ   = 2'd1;
  localparam logic [1:0] ENT_RDATA = 2'd2;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] acct;
    logic [63:0] data;
  } entry_t;

  typedef struct packed {
    logic       load_req;
    logic [2:0] idx_op;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       wr_from_req;
    logic [1:0] cnt_op;
    logic       stage;
    logic [1:0] stage_status;
    logic [1:0] stage_ent;
    logic       stage_pos_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       cnt_zero;
    logic       cnt_full;
    logic       idx_zero;
    logic       idx_eq_cnt;
    logic       pos_oor;
    logic       prio_gt;
    logic       acct_eq;
  } sts_t;

endpackage

// ===== hw/rtl/spq_ctrl.sv =====
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  spq_pkg::sts_t sts,
  output spq_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_INS_CHK  = 4'd2;
  localparam logic [3:0] S_INS_CMP  = 4'd3;
  localparam logic [3:0] S_DEQ_HEAD = 4'd4;
  localparam logic [3:0] S_DEQ_CHK  = 4'd5;
  localparam logic [3:0] S_DEQ_MOV  = 4'd6;
  localparam logic [3:0] S_PEEK     = 4'd7;
  localparam logic [3:0] S_FIND_CHK = 4'd8;
  localparam logic [3:0] S_FIND_CMP = 4'd9;
  localparam logic [3:0] S_RD_DATA  = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  logic [3:0] state, state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.mode) inside
          spq_pkg::MODE_ENQ: begin
            if (sts.cnt_full) begin
              cmd.stage = 1'b1;
              cmd.stage_status = spq_pkg::ST_FULL;
              state_next = S_FIN;
            end else begin
              cmd.idx_op = spq_pkg::IDX_CNT;
              state_next = S_INS_CHK;
            end
          end
          spq_pkg::MODE_DEQ, spq_pkg::MODE_PEEK: begin
            if (sts.cnt_zero) begin
              cmd.stage = 1'b1;
              cmd.stage_status = spq_pkg::ST_EMPTY;
              state_next = S_FIN;
            end else begin
              cmd.rd_en = 1'b1;
              cmd.rd_sel = spq_pkg::ADDR_ZERO;
              cmd.idx_op = spq_pkg::IDX_ONE;
              state_next = (sts.mode == spq_pkg::MODE_DEQ) ? S_DEQ_HEAD : S_PEEK;
            end
          end
          spq_pkg::MODE_FIND: begin
            cmd.idx_op = spq_pkg::IDX_ZERO;
            state_next = S_FIND_CHK;
          end
          spq_pkg::MODE_READ: begin
            if (sts.pos_oor) begin
              cmd.stage = 1'b1;
              cmd.stage_status = spq_pkg::ST_NOTFOUND;
              state_next = S_FIN;
            end else begin
              cmd.rd_en = 1'b1;
              cmd.rd_sel = spq_pkg::ADDR_POS;
              cmd.idx_op = spq_pkg::IDX_POS;
              state_next = S_RD_DATA;
            end
          end
          default: begin
            cmd.stage = 1'b1;
            cmd.stage_status = spq_pkg::ST_NOTFOUND;
            state_next = S_FIN;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = spq_pkg::ADDR_IDX;
          cmd.wr_from_req = 1'b1;
          cmd.cnt_op = spq_pkg::CNT_INC;
          cmd.stage = 1'b1;
          cmd.stage_status = spq_pkg::ST_OK;
          cmd.stage_ent = spq_pkg::ENT_REQ;
          cmd.stage_pos_idx = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = spq_pkg::ADDR_IDXM;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = spq_pkg::ADDR_IDX;
        if (sts.prio_gt) begin
          cmd.idx_op = spq_pkg::IDX_DEC;
          state_next = S_INS_CHK;
        end else begin
          cmd.wr_from_req = 1'b1;
          cmd.cnt_op = spq_pkg::CNT_INC;
          cmd.stage = 1'b1;
          cmd.stage_status = spq_pkg::ST_OK;
          cmd.stage_ent = spq_pkg::ENT_REQ;
          cmd.stage_pos_idx = 1'b1;
          state_next = S_FIN;
        end
      end
      S_DEQ_HEAD: begin
        cmd.stage = 1'b1;
        cmd.stage_status = spq_pkg::ST_OK;
        cmd.stage_ent = spq_pkg::ENT_RDATA;
        state_next = S_DEQ_CHK;
      end
      S_DEQ_CHK: begin
        if (sts.idx_eq_cnt) begin
          cmd.cnt_op = spq_pkg::CNT_DEC;
          state_next = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = spq_pkg::ADDR_IDX;
          state_next = S_DEQ_MOV;
        end
      end
      S_DEQ_MOV: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = spq_pkg::ADDR_IDXM;
        cmd.idx_op = spq_pkg::IDX_INC;
        state_next = S_DEQ_CHK;
      end
      S_PEEK: begin
        cmd.stage = 1'b1;
        cmd.stage_status = spq_pkg::ST_OK;
        cmd.stage_ent = spq_pkg::ENT_RDATA;
        state_next = S_FIN;
      end
      S_FIND_CHK: begin
        if (sts.idx_eq_cnt) begin
          cmd.stage = 1'b1;
          cmd.stage_status = spq_pkg::ST_NOTFOUND;
          state_next = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = spq_pkg::ADDR_IDX;
          state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (sts.acct_eq) begin
          cmd.stage = 1'b1;
          cmd.stage_status = spq_pkg::ST_OK;
          cmd.stage_ent = spq_pkg::ENT_RDATA;
          cmd.stage_pos_idx = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.idx_op = spq_pkg::IDX_INC;
          state_next = S_FIND_CHK;
        end
      end
      S_RD_DATA: begin
        cmd.stage = 1'b1;
        cmd.stage_status = spq_pkg::ST_OK;
        cmd.stage_ent = spq_pkg::ENT_RDATA;
        cmd.stage_pos_idx = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/spq_dp.sv =====
module spq_dp #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  spq_pkg::cmd_t cmd,
  output spq_pkg::sts_t sts,
  input  logic [2:0]    mode,
  input  logic [7:0]    priority_req,
  input  logic [31:0]   account_key,
  input  logic [63:0]   payload_in,
  input  logic [3:0]    slot_index,
  output logic [1:0]    status,
  output logic [31:0]   account_out,
  output logic [63:0]   payload_out,
  output logic [7:0]    priority_out,
  output logic [3:0]    found_slot,
  output logic [4:0]    occupancy
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::entry_t mem [QUEUE_DEPTH];
  spq_pkg::entry_t rdata;
  spq_pkg::entry_t req_ent;
  spq_pkg::entry_t stg_ent;
  spq_pkg::entry_t wdata;

  logic [2:0]    req_mode;
  logic [3:0]    req_pos;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_m1;
  logic [1:0]    stg_status;
  logic [CW-1:0] stg_pos;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [31:0]   pos_w, stg_pos_w, count_w;

  assign idx_m1  = idx - CW'(1);
  assign pos_w   = 32'(req_pos);
  assign count_w = 32'(count);

  always_comb begin
    case (cmd.rd_sel)
      spq_pkg::ADDR_IDX:  rd_addr = idx[IW-1:0];
      spq_pkg::ADDR_IDXM: rd_addr = idx_m1[IW-1:0];
      spq_pkg::ADDR_POS:  rd_addr = pos_w[IW-1:0];
      default:            rd_addr = '0;
    endcase
    case (cmd.wr_sel)
      spq_pkg::ADDR_IDXM: wr_addr = idx_m1[IW-1:0];
      default:            wr_addr = idx[IW-1:0];
    endcase
    wdata = cmd.wr_from_req ? req_ent : rdata;
    case (cmd.cnt_op)
      spq_pkg::CNT_INC: count_next = count + CW'(1);
      spq_pkg::CNT_DEC: count_next = count - CW'(1);
      default:          count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode     <= mode;
      req_pos      <= slot_index;
      req_ent.prio <= priority_req;
      req_ent.acct <= account_key;
      req_ent.data <= payload_in;
    end
    case (cmd.idx_op)
      spq_pkg::IDX_CNT:  idx <= count;
      spq_pkg::IDX_ZERO: idx <= '0;
      spq_pkg::IDX_ONE:  idx <= CW'(1);
      spq_pkg::IDX_POS:  idx <= pos_w[CW-1:0];
      spq_pkg::IDX_INC:  idx <= idx + CW'(1);
      spq_pkg::IDX_DEC:  idx <= idx_m1;
      default:           idx <= idx;
    endcase
    if (cmd.stage) begin
      stg_status <= cmd.stage_status;
      stg_pos    <= cmd.stage_pos_idx ? idx : '0;
      case (cmd.stage_ent)
        spq_pkg::ENT_REQ:   stg_ent <= req_ent;
        spq_pkg::ENT_RDATA: stg_ent <= rdata;
        default:            stg_ent <= '0;
      endcase
    end
  end

  assign stg_pos_w = 32'(stg_pos);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= stg_status;
      account_out  <= stg_ent.acct;
      payload_out  <= stg_ent.data;
      priority_out <= stg_ent.prio;
      found_slot   <= stg_pos_w[3:0];
      occupancy    <= count_w[4:0];
    end
  end

  assign sts.mode       = req_mode;
  assign sts.cnt_zero   = (count == '0);
  assign sts.cnt_full   = (count >= CW'(QUEUE_DEPTH));
  assign sts.idx_zero   = (idx == '0);
  assign sts.idx_eq_cnt = (idx == count);
  assign sts.pos_oor    = (pos_w >= count_w);
  assign sts.prio_gt    = (rdata.prio > req_ent.prio);
  assign sts.acct_eq    = (rdata.acct == req_ent.acct);

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue: entries kept in ascending priority number, ties in
// arrival order, QUEUE_DEPTH entries in a single-port-read memory.
// Input channel (in_valid / in_stall) carries one request word: mode,
// priority_req, account_key, payload_in, slot_index. Output channel
// (out_valid / out_stall) returns one result word per request.
// One request is in flight at a time; in_stall is high from acceptance until
// its result is loaded into the output register. Full, empty, out-of-range
// and unknown-mode requests finish without a memory access; peek and
// read-by-position do a single read. Enqueue, dequeue and find walk the
// entries one at a time: each step reads the memory, waits for the
// registered read data, then compares or writes back.
// Reset clears the entry count and the handshake state; memory contents are
// not cleared and are never returned before being written.
// When the receiver stalls, the result word holds; the next request may be
// accepted and worked on, and waits for the output register to free up.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  priority_req,
  input  logic [31:0] account_key,
  input  logic [63:0] payload_in,
  input  logic [3:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] account_out,
  output logic [63:0] payload_out,
  output logic [7:0]  priority_out,
  output logic [3:0]  found_slot,
  output logic [4:0]  occupancy
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .priority_req (priority_req),
    .account_key  (account_key),
    .payload_in   (payload_in),
    .slot_index   (slot_index),
    .status       (status),
    .account_out  (account_out),
    .payload_out  (payload_out),
    .priority_out (priority_out),
    .found_slot   (found_slot),
    .occupancy    (occupancy)
  );

endmodule

// ===== tb/sv/tb.sv =====
localparam int DEPTH = spq_pkg::QUEUE_DEPTH_DEF;

typedef struct packed {
  logic [2:0]  mode;
  logic [7:0]  prio;
  logic [31:0] acct;
  logic [63:0] data;
  logic [3:0]  slot;
} request_t;

typedef struct packed {
  logic [1:0]  status;
  logic [31:0] acct;
  logic [63:0] data;
  logic [7:0]  prio;
  logic [3:0]  slot;
  logic [4:0]  occ;
} answer_t;

class queue_scoreboard;
  spq_pkg::entry_t shadow[DEPTH];
  int              shadow_count;
  answer_t         awaited[$];
  int              fails;

  function new();
    shadow_count = 0;
    fails = 0;
  endfunction

  function answer_t hit(spq_pkg::entry_t e, int pos);
    answer_t a;
    a = '0;
    a.status = spq_pkg::ST_OK;
    a.acct = e.acct;
    a.data = e.data;
    a.prio = e.prio;
    a.slot = pos[3:0];
    return a;
  endfunction

  function void note_request(request_t r);
    answer_t         a;
    spq_pkg::entry_t head;
    int              i;
    a = '0;
    a.status = spq_pkg::ST_NOTFOUND;
    case (r.mode)
      spq_pkg::MODE_ENQ: begin
        if (shadow_count >= DEPTH) begin
          a.status = spq_pkg::ST_FULL;
        end else begin
          i = shadow_count;
          while (i > 0 && shadow[i-1].prio > r.prio) begin
            shadow[i] = shadow[i-1];
            i--;
          end
          shadow[i] = '{prio: r.prio, acct: r.acct, data: r.data};
          shadow_count++;
          a = hit(shadow[i], i);
        end
      end
      spq_pkg::MODE_DEQ: begin
        if (shadow_count == 0) begin
          a.status = spq_pkg::ST_EMPTY;
        end else begin
          head = shadow[0];
          for (i = 1; i < shadow_count; i++) shadow[i-1] = shadow[i];
          shadow_count--;
          a = hit(head, 0);
        end
      end
      spq_pkg::MODE_PEEK: begin
        if (shadow_count == 0) a.status = spq_pkg::ST_EMPTY;
        else a = hit(shadow[0], 0);
      end
      spq_pkg::MODE_FIND: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow[i].acct == r.acct) begin
            a = hit(shadow[i], i);
            break;
          end
        end
      end
      spq_pkg::MODE_READ: begin
        if (r.slot < shadow_count) a = hit(shadow[r.slot], r.slot);
      end
      default: ;
    endcase
    a.occ = shadow_count[4:0];
    awaited.push_back(a);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    fails++;
  endtask

  task check_result(answer_t got);
    answer_t want;
    if (awaited.size() == 0) begin
      report("unexpected word", 64'(got.status), 64'(got.occ));
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
    if (got.acct !== want.acct) report("account_out", 64'(got.acct), 64'(want.acct));
    if (got.data !== want.data) report("payload_out", got.data, want.data);
    if (got.prio !== want.prio) report("priority_out", 64'(got.prio), 64'(want.prio));
    if (got.slot !== want.slot) report("found_slot", 64'(got.slot), 64'(want.slot));
    if (got.occ !== want.occ) report("occupancy", 64'(got.occ), 64'(want.occ));
  endtask
endclass

module tb;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEM_TARGET = 550;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  mode;
  logic [7:0]  priority_req;
  logic [31:0] account_key;
  logic [63:0] payload_in;
  logic [3:0]  slot_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] account_out;
  logic [63:0] payload_out;
  logic [7:0]  priority_out;
  logic [3:0]  found_slot;
  logic [4:0]  occupancy;

  queue_scoreboard sb;
  bit calm;
  int items_sent;
  int quiet;

  sorted_priority_queue u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .priority_req(priority_req), .account_key(account_key),
    .payload_in(payload_in), .slot_index(slot_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .account_out(account_out), .payload_out(payload_out),
    .priority_out(priority_out), .found_slot(found_slot), .occupancy(occupancy)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic request_t mk(logic [2:0] m, logic [7:0] p, logic [31:0] a,
                                  logic [63:0] d, logic [3:0] s);
    request_t r;
    r.mode = m;
    r.prio = p;
    r.acct = a;
    r.data = d;
    r.slot = s;
    return r;
  endfunction

  function automatic request_t random_request(bit filling);
    request_t r;
    int roll;
    int enq_pct;
    int deq_pct;
    r = mk(spq_pkg::MODE_ENQ, 8'($urandom), $urandom, {$urandom, $urandom},
           4'($urandom));
    enq_pct = filling ? 60 : 15;
    deq_pct = enq_pct + (filling ? 10 : 40);
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) r.mode = spq_pkg::MODE_ENQ;
    else if (roll < deq_pct) r.mode = spq_pkg::MODE_DEQ;
    else if (roll < deq_pct + 7) r.mode = spq_pkg::MODE_PEEK;
    else if (roll < deq_pct + 17) r.mode = spq_pkg::MODE_FIND;
    else if (roll < deq_pct + 26) r.mode = spq_pkg::MODE_READ;
    else r.mode = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 1)) r.prio = 8'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) r.acct = $urandom_range(0, 7);
    if (r.mode == spq_pkg::MODE_FIND && sb.shadow_count > 0 && $urandom_range(0, 2) != 0)
      r.acct = sb.shadow[$urandom_range(0, sb.shadow_count - 1)].acct;
    if (r.mode == spq_pkg::MODE_READ && sb.shadow_count > 0 && $urandom_range(0, 1))
      r.slot = 4'($urandom_range(0, sb.shadow_count - 1));
    return r;
  endfunction

  task automatic push_request(request_t r);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = r.mode;
    priority_req = r.prio;
    account_key = r.acct;
    payload_in = r.data;
    slot_index = r.slot;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(r);
    items_sent++;
  endtask

  // result side
  initial begin
    int k;
    answer_t got;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      k = draw_wait();
      if (k > 0) begin
        out_stall = 1'b1;
        repeat (k) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{status: status, acct: account_out, data: payload_out,
              prio: priority_out, slot: found_slot, occ: occupancy};
      sb.check_result(got);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] d;
    bit filling;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = '0;
    priority_req = '0;
    account_key = '0;
    payload_in = '0;
    slot_index = '0;
    calm = 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue and unknown modes
    push_request(mk(spq_pkg::MODE_DEQ, '0, '0, '0, '0));
    push_request(mk(spq_pkg::MODE_PEEK, '1, '1, '1, '1));
    push_request(mk(spq_pkg::MODE_FIND, '0, '1, '0, '0));
    push_request(mk(spq_pkg::MODE_READ, '0, '0, '0, '0));
    push_request(mk(3'd5, '1, '1, '1, '1));
    push_request(mk(3'd7, '1, '1, '1, '1));
    // fill to the top with extreme priorities and ties
    for (int k = 0; k < DEPTH; k++) begin
      d = (k == 1) ? '1 : (k == 0) ? '0 : {$urandom, $urandom};
      push_request(mk(spq_pkg::MODE_ENQ,
                      (k % 4 == 0) ? 8'hFF : (k % 4 == 1) ? 8'h00 : 8'(k * 16),
                      (k == 1) ? 32'hFFFF_FFFF : 32'(k) * 32'h1111_1110,
                      d, 4'(k)));
    end
    push_request(mk(spq_pkg::MODE_ENQ, 8'h00, 32'h1234_5678, '1, '0));
    push_request(mk(spq_pkg::MODE_FIND, '0, 32'hFFFF_FFFF, '0, '0));
    push_request(mk(spq_pkg::MODE_FIND, '0, 32'h8000_0001, '0, '0));
    push_request(mk(spq_pkg::MODE_READ, '0, '0, '0, 4'd15));
    push_request(mk(spq_pkg::MODE_PEEK, '0, '0, '0, '0));
    push_request(mk(spq_pkg::MODE_DEQ, '0, '0, '0, '0));
    push_request(mk(3'd6, '0, '0, '0, '0));

    filling = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < 30 && items_sent < ITEM_TARGET; j++)
        push_request(random_request(filling));
      filling = !filling;
    end

    @(negedge clk);
    in_valid = 1'b0;
    calm = 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
